>>> design/fcc_pkg.sv
// Package for the fence coloring counter: widths, the prime modulus,
// modular helper functions and the controller/datapath command and status words.
// No dependencies.
package fcc_pkg;

  // Field widths
  localparam int COUNT_BITS = 16;
  localparam int VAL_W      = 30;

  // Prime modulus and its Barrett constant floor(2^60 / P)
  localparam logic [VAL_W-1:0] PRIME   = 30'd1000000007;
  localparam logic [63:0]      MU_WIDE = (64'd1 << 60) / 64'(PRIME);
  localparam logic [30:0]      MU      = MU_WIDE[30:0];

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new input word
    logic set_zero;   // result is zero (no posts)
    logic set_k;      // result is k (one post)
    logic mul_init;   // issue k * (k-1)
    logic init_done;  // newer = k + k*(k-1), older = k
    logic add_step;   // sum = newer + older, count down
    logic mul_step;   // issue sum * (k-1)
    logic step_done;  // shift the recurrence window
    logic out_load;   // move result into the output register
  } fcc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic remain_zero;
    logic mul_done;
  } fcc_sts_t;

  // Sum of two residues, reduced once
  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[VAL_W-1:0];
  endfunction

  // A 30-bit value is below 2P, so one subtract reduces it
  function automatic logic [VAL_W-1:0] mod_reduce(input logic [VAL_W-1:0] a);
    return (a >= PRIME) ? (a - PRIME) : a;
  endfunction

endpackage

>>> design/fcc_ifs.sv
// Valid/ready channel interfaces for the fence coloring counter:
// request words (post count, color count) and result words (ways).
// Depends on fcc_pkg.
interface fcc_in_if
  import fcc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] post_count;
  logic [VAL_W-1:0]      color_count;

  modport source(output valid, post_count, color_count, input ready);
  modport sink(input valid, post_count, color_count, output ready);
endinterface

interface fcc_out_if
  import fcc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] ways;

  modport source(output valid, ways, input ready);
  modport sink(input valid, ways, output ready);
endinterface

>>> design/fcc_mulmod.sv
// Four-stage pipelined modular multiplier, a*b mod P, using Barrett reduction.
// Depends on fcc_pkg.
module fcc_mulmod
  import fcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             done,
  output logic [VAL_W-1:0] prod
);

  logic [3:0]       vld_r;
  logic [59:0]      p1_r;
  logic [61:0]      q2_r;
  logic [31:0]      x2_r;
  logic [31:0]      qp_r;
  logic [31:0]      x3_r;
  logic [VAL_W-1:0] prod_r;
  logic [60:0]      qp_full;
  logic [31:0]      rem;
  logic [31:0]      rem_fix;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  // Stage 1: full product; stage 2: quotient estimate; stage 3: q*P
  assign qp_full = q2_r[61:31] * PRIME;

  always_ff @(posedge clk) begin
    p1_r <= a * b;
    q2_r <= p1_r[59:29] * MU;
    x2_r <= p1_r[31:0];
    qp_r <= qp_full[31:0];
    x3_r <= x2_r;
  end

  // Stage 4: remainder is below 3P, at most two corrections
  assign rem = x3_r - qp_r;

  always_comb begin
    if (rem >= {PRIME, 1'b0} + 32'd0) begin
      rem_fix = rem - {1'b0, PRIME, 1'b0};
    end else if (rem >= {2'b00, PRIME}) begin
      rem_fix = rem - {2'b00, PRIME};
    end else begin
      rem_fix = rem;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= rem_fix[VAL_W-1:0];
  end

  assign done = vld_r[3];
  assign prod = prod_r;

endmodule

>>> design/fcc_datapath.sv
// Datapath of the fence coloring counter: operand registers, step counter,
// recurrence window, modular multiplier and the output word register.
// Depends on fcc_pkg and fcc_mulmod.
module fcc_datapath
  import fcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  fcc_cmd_t              cmd,
  output fcc_sts_t              sts,
  input  logic [COUNT_BITS-1:0] post_count,
  input  logic [VAL_W-1:0]      color_count,
  output logic [VAL_W-1:0]      ways
);

  logic [COUNT_BITS-1:0] n_r;
  logic [COUNT_BITS-1:0] remain_r;
  logic [VAL_W-1:0]      k_r;
  logic [VAL_W-1:0]      km1_r;
  logic [VAL_W-1:0]      older_r;
  logic [VAL_W-1:0]      newer_r;
  logic [VAL_W-1:0]      sum_r;
  logic [VAL_W-1:0]      ways_r;
  logic [VAL_W-1:0]      k_red;
  logic [VAL_W-1:0]      mul_a;
  logic [VAL_W-1:0]      mul_prod;
  logic                  mul_done;

  // Color count as a residue
  assign k_red = mod_reduce(color_count);

  // Multiplier operand select
  assign mul_a = cmd.mul_step ? sum_r : k_r;

  fcc_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_init | cmd.mul_step),
    .a     (mul_a),
    .b     (km1_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Operand and counter registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= post_count;
      remain_r <= post_count - COUNT_BITS'(2);
      k_r      <= k_red;
      km1_r    <= (k_red == '0) ? (PRIME - VAL_W'(1)) : (k_red - VAL_W'(1));
    end else if (cmd.add_step) begin
      remain_r <= remain_r - COUNT_BITS'(1);
    end
  end

  // Recurrence window
  always_ff @(posedge clk) begin
    if (cmd.set_zero) begin
      newer_r <= '0;
    end else if (cmd.set_k) begin
      newer_r <= k_r;
    end else if (cmd.init_done) begin
      older_r <= k_r;
      newer_r <= mod_add(k_r, mul_prod);
    end else if (cmd.step_done) begin
      older_r <= newer_r;
      newer_r <= mul_prod;
    end
    if (cmd.add_step) begin
      sum_r <= mod_add(newer_r, older_r);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ways_r <= newer_r;
    end
  end

  assign ways             = ways_r;
  assign sts.n_zero       = (n_r == '0);
  assign sts.n_one        = (n_r == COUNT_BITS'(1));
  assign sts.remain_zero  = (remain_r == '0);
  assign sts.mul_done     = mul_done;

endmodule

>>> design/fcc_ctrl.sv
// Controller of the fence coloring counter: sequences the recurrence steps
// and owns the handshake and the output valid flag.
// Depends on fcc_pkg.
module fcc_ctrl
  import fcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output fcc_cmd_t cmd,
  input  fcc_sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_WINIT  = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_WMUL   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.n_zero) begin
          cmd.set_zero = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (sts.n_one) begin
          cmd.set_k = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          cmd.mul_init = 1'b1;
          state_nxt    = ST_WINIT;
        end
      end
      ST_WINIT: begin
        if (sts.mul_done) begin
          cmd.init_done = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.remain_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.add_step = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = ST_WMUL;
      end
      ST_WMUL: begin
        if (sts.mul_done) begin
          cmd.step_done = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/fence_coloring_count_mod_prime_unit.sv
// Fence coloring counter: for a request word with post count n and color
// count k it returns the number of ways to paint n posts with k colors, no
// more than two neighbors alike, modulo 1000000007. Requests are handled one
// at a time. Each recurrence step runs an add, then issues a product to the
// four-stage modular multiplier and waits for its result. A finished result
// sits in an output register, so the next request is taken while it waits.
// Depends on fcc_pkg, fcc_ifs, fcc_ctrl, fcc_datapath.
module fence_coloring_count_mod_prime_unit
  import fcc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  fcc_in_if.sink    in_ch,
  fcc_out_if.source out_ch
);

  fcc_cmd_t cmd;
  fcc_sts_t sts;

  fcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fcc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .post_count  (in_ch.post_count),
    .color_count (in_ch.color_count),
    .ways        (out_ch.ways)
  );

endmodule

>>> design/fcc_checker.sv
// Port-level checker for the fence coloring counter, bound to the top level.
// Depends on fcc_pkg and fence_coloring_count_mod_prime_unit.
module fcc_checker
  import fcc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] ways
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(ways))
    else $error("result word changed while stalled");

  // One request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Every result is a residue
  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ways < PRIME))
    else $error("result not reduced");

endmodule

bind fence_coloring_count_mod_prime_unit fcc_checker u_fcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .ways      (out_ch.ways)
);
